@@ sv/gafp_pkg.sv @@
// gafp_pkg: constants and types shared by the gimbal angle frame parser
// no dependencies
package gafp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned POS_W   = 5;

    localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'hEE;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h90;

    // frame position codes
    localparam logic [POS_W-1:0] POS_HUNT     = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR      = 5'd1;
    localparam logic [POS_W-1:0] POS_BODY     = 5'd2;
    localparam logic [POS_W-1:0] POS_YAW_LO   = 5'd16;
    localparam logic [POS_W-1:0] POS_YAW_HI   = 5'd17;
    localparam logic [POS_W-1:0] POS_PITCH_LO = 5'd18;
    localparam logic [POS_W-1:0] POS_PITCH_HI = 5'd19;
    localparam logic [POS_W-1:0] POS_CHECK    = 5'd31;

    typedef struct packed {
        logic [ANGLE_W-1:0] yaw;
        logic [ANGLE_W-1:0] pitch;
    } t_result;

    // result transfer from parser to output buffer
    typedef struct packed {
        logic    push;
        t_result data;
    } t_res_xfer;

endpackage

@@ sv/gafp_parser.sv @@
// gafp_parser: frame position, checksum and angle capture registers
// depends on gafp_pkg
module gafp_parser (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_step,
    input  logic [gafp_pkg::BYTE_W-1:0] i_byte,
    output gafp_pkg::t_res_xfer         o_res
);

    logic [gafp_pkg::POS_W-1:0]   r_pos,   n_pos;
    logic [gafp_pkg::BYTE_W-1:0]  r_sum,   n_sum;
    logic [gafp_pkg::ANGLE_W-1:0] r_yaw,   n_yaw;
    logic [gafp_pkg::ANGLE_W-1:0] r_pitch, n_pitch;
    logic                         hit;

    always_comb begin
        n_pos   = r_pos;
        n_sum   = r_sum;
        n_yaw   = r_yaw;
        n_pitch = r_pitch;
        hit     = 1'b0;
        priority if (r_pos == gafp_pkg::POS_HUNT) begin
            if (i_byte == gafp_pkg::HDR_FIRST) n_pos = gafp_pkg::POS_HDR;
        end else if (r_pos == gafp_pkg::POS_HDR) begin
            if (i_byte == gafp_pkg::HDR_SECOND) begin
                n_pos = gafp_pkg::POS_BODY;
                n_sum = '0;
            end else begin
                n_pos = gafp_pkg::POS_HUNT;
            end
        end else if (r_pos == gafp_pkg::POS_CHECK) begin
            hit   = (r_sum == i_byte);
            n_pos = gafp_pkg::POS_HUNT;
        end else begin
            n_sum = r_sum + i_byte;
            unique case (r_pos)
                gafp_pkg::POS_YAW_LO:   n_yaw   = {{(gafp_pkg::ANGLE_W-gafp_pkg::BYTE_W){1'b0}},
                                                   i_byte};
                gafp_pkg::POS_YAW_HI:   n_yaw   = {i_byte, r_yaw[gafp_pkg::BYTE_W-1:0]};
                gafp_pkg::POS_PITCH_LO: n_pitch = {{(gafp_pkg::ANGLE_W-gafp_pkg::BYTE_W){1'b0}},
                                                   i_byte};
                gafp_pkg::POS_PITCH_HI: n_pitch = {i_byte, r_pitch[gafp_pkg::BYTE_W-1:0]};
                default: ;
            endcase
            n_pos = r_pos + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= gafp_pkg::POS_HUNT;
            r_sum   <= '0;
            r_yaw   <= '0;
            r_pitch <= '0;
        end else if (i_step) begin
            r_pos   <= n_pos;
            r_sum   <= n_sum;
            r_yaw   <= n_yaw;
            r_pitch <= n_pitch;
        end
    end

    assign o_res.push       = i_step & hit;
    assign o_res.data.yaw   = r_yaw;
    assign o_res.data.pitch = r_pitch;

    a_check_returns_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_pos == gafp_pkg::POS_CHECK) |=> (r_pos == gafp_pkg::POS_HUNT))
        else $error("parser did not return to hunt after checksum byte");

    a_push_only_at_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.push |-> (r_pos == gafp_pkg::POS_CHECK))
        else $error("result pushed outside checksum position");

    a_header_clears_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && r_pos == gafp_pkg::POS_HDR && i_byte == gafp_pkg::HDR_SECOND)
        |=> (r_sum == '0 && r_pos == gafp_pkg::POS_BODY))
        else $error("checksum not restarted at header");

endmodule

@@ sv/gafp_out_buf.sv @@
// gafp_out_buf: two-entry result buffer, head register plus skid register
// depends on gafp_pkg
module gafp_out_buf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  gafp_pkg::t_res_xfer i_res,
    output logic                o_full,
    output logic                o_valid,
    input  logic                i_ready,
    output gafp_pkg::t_result   o_data
);

    logic [1:0]        r_count, n_count;
    gafp_pkg::t_result r_head;
    gafp_pkg::t_result r_skid;
    logic              pop;

    assign pop     = o_valid & i_ready;
    assign o_valid = (r_count != 2'd0);
    assign o_full  = (r_count == 2'd2);
    assign o_data  = r_head;

    always_comb begin
        n_count = r_count;
        if (i_res.push && !pop)      n_count = r_count + 2'd1;
        else if (!i_res.push && pop) n_count = r_count - 2'd1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_count == 2'd2) begin
            if (pop) r_head <= r_skid;
        end else if (i_res.push) begin
            if (r_count == 2'd0 || pop) r_head <= i_res.data;
            else                        r_skid <= i_res.data;
        end
    end

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count != 2'd3)
        else $error("result buffer count out of range");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_res.push)
        else $error("result pushed into full buffer");

    a_skid_drains_to_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && pop) |=> (r_head == $past(r_skid) && r_count == 2'd1))
        else $error("skid entry lost on drain");

endmodule

@@ sv/gimbal_angle_frame_parser_top.sv @@
// gimbal_angle_frame_parser_top: input register, frame parser and result buffer
// depends on gafp_pkg, gafp_parser, gafp_out_buf
// path: input register, then buffer head register, to o_valid when buffer has room
// throughput: one byte per cycle while the result buffer is not full; its two
//   entries keep input flowing while one result waits for i_ready
// reset: synchronous active-low i_rst_n clears position, checksum, captures
//   and all valid flags; parser starts hunting for the header
module gimbal_angle_frame_parser_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [gafp_pkg::BYTE_W-1:0]  i_rx_byte,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [gafp_pkg::ANGLE_W-1:0] o_yaw_angle,
    output logic [gafp_pkg::ANGLE_W-1:0] o_pitch_angle
);

    logic                        r_in_valid;
    logic [gafp_pkg::BYTE_W-1:0] r_in_byte;
    logic                        step;
    logic                        buf_full;
    gafp_pkg::t_res_xfer         res;
    gafp_pkg::t_result           out_data;

    // parser advances only when the buffer can take a possible result
    assign step    = r_in_valid & ~buf_full;
    assign o_ready = ~r_in_valid | step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) r_in_byte <= i_rx_byte;
    end

    gafp_parser u_parser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_byte  (r_in_byte),
        .o_res   (res)
    );

    gafp_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_full  (buf_full),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (out_data)
    );

    assign o_yaw_angle   = out_data.yaw;
    assign o_pitch_angle = out_data.pitch;

endmodule

@@ sim/gimbal_angle_frame_parser_top_test.sv @@
// gimbal_angle_frame_parser_top_test: self-checking bench for the gimbal angle frame parser
// drives serial bytes and tracks frame position, checksum and angle captures in parallel
// depends on gafp_pkg and gimbal_angle_frame_parser_top
`timescale 1ns / 100ps

module gimbal_angle_frame_parser_top_test;

    typedef logic [gafp_pkg::BYTE_W-1:0]  t_byte;
    typedef logic [gafp_pkg::ANGLE_W-1:0] t_angle;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RANDOM_BYTES   = 850;
    localparam int DRAIN_LIMIT    = 2000;
    localparam int TAIL_CYCLES    = 10;
    localparam int MAX_REPORTS    = 10;

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic [gafp_pkg::BYTE_W-1:0]   i_rx_byte;
    logic                          o_valid;
    logic                          i_ready;
    logic [gafp_pkg::ANGLE_W-1:0]  o_yaw_angle;
    logic [gafp_pkg::ANGLE_W-1:0]  o_pitch_angle;

    // predicted parser state
    logic [gafp_pkg::POS_W-1:0]    track_pos;
    logic [gafp_pkg::BYTE_W-1:0]   track_sum;
    logic [gafp_pkg::ANGLE_W-1:0]  track_yaw;
    logic [gafp_pkg::ANGLE_W-1:0]  track_pitch;

    gafp_pkg::t_result   angle_expect_q [$];

    int                  cycle_count;
    int                  mismatch_count;
    int                  rx_byte_count;
    bit                  idle_en;
    bit                  stall_en;
    bit                  hold_req;

    gimbal_angle_frame_parser_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_yaw_angle   (o_yaw_angle),
        .o_pitch_angle (o_pitch_angle)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // advance the predicted parser by one accepted byte
    task automatic track_frame_byte(input logic [gafp_pkg::BYTE_W-1:0] b);
        gafp_pkg::t_result res;
        case (track_pos)
            gafp_pkg::POS_HUNT: begin
                if (b == gafp_pkg::HDR_FIRST) track_pos = gafp_pkg::POS_HDR;
            end
            gafp_pkg::POS_HDR: begin
                if (b == gafp_pkg::HDR_SECOND) begin
                    track_pos = gafp_pkg::POS_BODY;
                    track_sum = '0;
                end else begin
                    track_pos = gafp_pkg::POS_HUNT;
                end
            end
            gafp_pkg::POS_CHECK: begin
                if (track_sum == b) begin
                    res.yaw   = track_yaw;
                    res.pitch = track_pitch;
                    angle_expect_q.push_back(res);
                end
                track_pos = gafp_pkg::POS_HUNT;
            end
            default: begin
                track_sum = track_sum + b;
                case (track_pos)
                    gafp_pkg::POS_YAW_LO:   track_yaw   = {8'h00, b};
                    gafp_pkg::POS_YAW_HI:   track_yaw   = {b, track_yaw[7:0]};
                    gafp_pkg::POS_PITCH_LO: track_pitch = {8'h00, b};
                    gafp_pkg::POS_PITCH_HI: track_pitch = {b, track_pitch[7:0]};
                    default: ;
                endcase
                track_pos = track_pos + 1'b1;
            end
        endcase
    endtask

    task automatic send_rx_byte(input logic [gafp_pkg::BYTE_W-1:0] b);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (!o_ready);
        rx_byte_count++;
        track_frame_byte(b);
    endtask

    // full 32-byte frame; fill < 0 gives random body bytes
    task automatic send_frame(input logic [gafp_pkg::ANGLE_W-1:0] yaw,
                              input logic [gafp_pkg::ANGLE_W-1:0] pitch,
                              input bit sum_ok, input int fill);
        logic [gafp_pkg::BYTE_W-1:0] body [2:30];
        logic [gafp_pkg::BYTE_W-1:0] sum;
        sum = '0;
        for (int p = 2; p <= 30; p++) begin
            body[p] = (fill < 0) ? t_byte'($urandom_range(0, 255)) : t_byte'(fill);
        end
        body[gafp_pkg::POS_YAW_LO]   = yaw[7:0];
        body[gafp_pkg::POS_YAW_HI]   = yaw[15:8];
        body[gafp_pkg::POS_PITCH_LO] = pitch[7:0];
        body[gafp_pkg::POS_PITCH_HI] = pitch[15:8];
        for (int p = 2; p <= 30; p++) begin
            sum = sum + body[p];
        end
        if (!sum_ok) sum = sum ^ t_byte'($urandom_range(1, 255));
        send_rx_byte(gafp_pkg::HDR_FIRST);
        send_rx_byte(gafp_pkg::HDR_SECOND);
        for (int p = 2; p <= 30; p++) begin
            send_rx_byte(body[p]);
        end
        send_rx_byte(sum);
    endtask

    // receiver side: long hold-off on request, short random stalls when enabled
    initial begin
        forever begin
            if (hold_req) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall_en && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end else begin
                i_ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        gafp_pkg::t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (angle_expect_q.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected result: yaw %h pitch %h", o_yaw_angle, o_pitch_angle);
            end else begin
                want = angle_expect_q.pop_front();
                if (o_yaw_angle !== want.yaw || o_pitch_angle !== want.pitch) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("angle mismatch: expected yaw %h pitch %h, got yaw %h pitch %h",
                                 want.yaw, want.pitch, o_yaw_angle, o_pitch_angle);
                end
            end
        end
    end

    task automatic test_angle_extremes();
        send_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 1'b1, 8'hFF);
        send_frame(16'h8001, 16'h7FFE, 1'b1, -1);
    endtask

    // bad check byte gives nothing, next frame is summed from scratch
    task automatic test_checksum_mismatch();
        send_frame(16'h1234, 16'h5678, 1'b0, -1);
        send_frame(16'hA5A5, 16'h5A5A, 1'b1, 8'hFF);
    endtask

    task automatic test_header_slips();
        send_rx_byte(gafp_pkg::HDR_SECOND);
        send_rx_byte(gafp_pkg::HDR_FIRST);
        send_rx_byte(8'h55);
        // repeated first header byte must not restart the header
        send_rx_byte(gafp_pkg::HDR_FIRST);
        send_rx_byte(gafp_pkg::HDR_FIRST);
        send_rx_byte(gafp_pkg::HDR_SECOND);
        send_frame(16'h0F0F, 16'hF0F0, 1'b1, -1);
    endtask

    task automatic test_output_backpressure();
        hold_req = 1'b1;
        repeat (8) send_frame(t_angle'($urandom_range(0, 65535)),
                              t_angle'($urandom_range(0, 65535)), 1'b1, -1);
    endtask

    task automatic test_random_traffic();
        int kind;
        int start_bytes;
        idle_en     = 1'b1;
        stall_en    = 1'b1;
        start_bytes = rx_byte_count;
        while (rx_byte_count - start_bytes < RANDOM_BYTES) begin
            kind = $urandom_range(0, 99);
            if (kind < 65) begin
                send_frame(t_angle'($urandom_range(0, 65535)),
                           t_angle'($urandom_range(0, 65535)), 1'b1, -1);
            end else if (kind < 78) begin
                send_frame(t_angle'($urandom_range(0, 65535)),
                           t_angle'($urandom_range(0, 65535)), 1'b0, -1);
            end else if (kind < 86) begin
                repeat ($urandom_range(1, 12)) send_rx_byte(t_byte'($urandom_range(0, 255)));
            end else if (kind < 93) begin
                // cut-off frame, the following bytes land inside it
                send_rx_byte(gafp_pkg::HDR_FIRST);
                send_rx_byte(gafp_pkg::HDR_SECOND);
                repeat ($urandom_range(0, 28)) send_rx_byte(t_byte'($urandom_range(0, 255)));
            end else begin
                send_rx_byte(gafp_pkg::HDR_FIRST);
                send_rx_byte($urandom_range(0, 1) ? gafp_pkg::HDR_FIRST
                                                  : t_byte'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic test_steady_stream();
        idle_en  = 1'b0;
        stall_en = 1'b0;
        repeat (6) send_frame(t_angle'($urandom_range(0, 65535)),
                              t_angle'($urandom_range(0, 65535)), 1'b1, -1);
    endtask

    initial begin
        int drain;
        cycle_count        = 0;
        mismatch_count     = 0;
        rx_byte_count      = 0;
        idle_en            = 1'b0;
        stall_en           = 1'b0;
        hold_req           = 1'b0;
        track_pos          = gafp_pkg::POS_HUNT;
        track_sum          = '0;
        track_yaw          = '0;
        track_pitch        = '0;
        i_rst_n   <= 1'b0;
        i_valid   <= 1'b0;
        i_rx_byte <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_angle_extremes();
        test_checksum_mismatch();
        test_header_slips();
        test_output_backpressure();
        test_random_traffic();
        test_steady_stream();

        i_valid <= 1'b0;
        drain = 0;
        while (angle_expect_q.size() != 0 && drain < DRAIN_LIMIT) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (angle_expect_q.size() != 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0d expected results never arrived", angle_expect_q.size());
        end

        if (mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
